>>> hdl/event_timestamp_ascii_emitter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event timestamp ASCII emitter
// Clocked on clk_i; disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EVENT_TIMESTAMP_ASCII_EMITTER_ASSERT_SVH
`define EVENT_TIMESTAMP_ASCII_EMITTER_ASSERT_SVH

// Same-cycle implication
`define ETAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ETAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/etae_pkg.sv
// ----------------------------------------------------------------------------
// etae_pkg
// Shared constants and types for the event timestamp ASCII emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package etae_pkg;

  // Channels and index width
  localparam int NUM_CHANNELS = 2;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Field widths
  localparam int LOCKOUT_W = 16;
  localparam int TIME_W    = 32;
  localparam int TICKS_W   = 32;
  localparam int STAMP_W   = 64;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;

  // ticks / 10 as (ticks * magic) >> 35, exact for all 32-bit values
  localparam logic [TICKS_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;
  localparam int PROD_W      = 2 * TICKS_W;
  localparam int QUOT_W      = PROD_W - DIV10_SHIFT;

  // Decimal conversion
  localparam int NUM_DIGITS  = 20;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
  localparam int STEP_W      = $clog2(STAMP_W);

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_ONE   = 8'h31;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;

  // Register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_LOCKOUT = 3'h0;

  // Front-to-back queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               chan;
  } stamp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

>>> hdl/etae_front.sv
// ----------------------------------------------------------------------------
// etae_front
// Lockout filter per channel and timestamp build (base + ticks / 10).
// ----------------------------------------------------------------------------
`default_nettype none

module etae_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [etae_pkg::LOCKOUT_W-1:0]  lockout_i,
  input  wire logic                            s_valid_i,
  output logic                                 s_ready_o,
  input  wire logic                            channel_i,
  input  wire logic [etae_pkg::TIME_W-1:0]     now_ms_i,
  input  wire logic [etae_pkg::TICKS_W-1:0]    sub_ticks_i,
  input  wire logic [etae_pkg::STAMP_W-1:0]    base_time_i,
  input  wire logic                            base_valid_i,
  output logic                                 push_o,
  output etae_pkg::stamp_entry_t               push_data_o,
  input  wire etae_pkg::fifo_status_t          fifo_status_i
);
  import etae_pkg::*;

  logic [TIME_W-1:0]   last_ms_q [NUM_CHANNELS];
  logic [CH_IDX_W-1:0] idx;
  logic                chan_ok;
  logic [TIME_W-1:0]   elapsed;
  logic                pass;
  logic                accept;

  logic                s1_valid_q;
  logic                s1_chan_q;
  logic [TICKS_W-1:0]  s1_ticks_q;
  logic [STAMP_W-1:0]  s1_base_q;
  logic [PROD_W-1:0]   prod;

  logic                s2_valid_q;
  logic                s2_chan_q;
  logic [QUOT_W-1:0]   s2_quot_q;
  logic [STAMP_W-1:0]  s2_base_q;

  logic                s1_en;
  logic                s2_en;

  assign idx     = CH_IDX_W'(channel_i);
  assign chan_ok = ({31'b0, channel_i} < 32'(NUM_CHANNELS));
  assign elapsed = now_ms_i - last_ms_q[idx];
  assign pass    = chan_ok && (elapsed >= TIME_W'(lockout_i));

  assign s2_en     = !s2_valid_q || !fifo_status_i.full;
  assign s1_en     = !s1_valid_q || s2_en;
  assign s_ready_o = s1_en;
  assign accept    = s_valid_i && s1_en;

  // last accepted time per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_ms_q[i] <= '0;
      end
    end else if (accept && pass) begin
      last_ms_q[idx] <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= s_valid_i && pass && base_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chan_q  <= channel_i;
      s1_ticks_q <= sub_ticks_i;
      s1_base_q  <= base_time_i;
    end
    if (s2_en) begin
      s2_chan_q <= s1_chan_q;
      s2_quot_q <= prod[PROD_W-1:DIV10_SHIFT];
      s2_base_q <= s1_base_q;
    end
  end

  assign prod = s1_ticks_q * DIV10_MAGIC;

  assign push_o            = s2_valid_q && !fifo_status_i.full;
  assign push_data_o.stamp = s2_base_q + STAMP_W'(s2_quot_q);
  assign push_data_o.chan  = s2_chan_q;

endmodule

`default_nettype wire

>>> hdl/etae_fifo.sv
// ----------------------------------------------------------------------------
// etae_fifo
// Short register queue between the front filter and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module etae_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire etae_pkg::stamp_entry_t push_data_i,
  input  wire logic                   pop_i,
  output etae_pkg::stamp_entry_t      pop_data_o,
  output etae_pkg::fifo_status_t      status_o
);
  import etae_pkg::*;

  stamp_entry_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q;
  logic [FIFO_AW-1:0]    rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  function automatic logic [FIFO_AW-1:0] next_ptr(input logic [FIFO_AW-1:0] p);
    next_ptr = (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/etae_back.sv
// ----------------------------------------------------------------------------
// etae_back
// Binary to decimal conversion (shift-add-3) and record byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module etae_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire etae_pkg::fifo_status_t fifo_status_i,
  output logic                        pop_o,
  input  wire etae_pkg::stamp_entry_t pop_data_i,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output logic [7:0]                  m_byte_o,
  output logic                        m_last_o
);
  import etae_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_DIGIT,
    ST_COMMA,
    ST_CHAN,
    ST_CR,
    ST_LF
  } back_state_e;

  back_state_e            state_q;
  logic [STEP_W-1:0]      step_q;
  logic [DIGIT_CNT_W-1:0] left_q;
  logic                   chan_q;
  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic                   out_last_q;

  logic [STAMP_W-1:0]     bin_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   skip_now;
  logic                   byte_load;

  assign out_free  = !out_valid_q || m_ready_i;
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign skip_now  = (top_digit == 4'd0) && (left_q > DIGIT_CNT_W'(1));
  assign pop_o     = (state_q == ST_IDLE) && !fifo_status_i.empty;
  // a record byte goes into the output register this cycle
  assign byte_load = out_free &&
                     (state_q inside {ST_DIGIT, ST_COMMA, ST_CHAN, ST_CR, ST_LF});

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      left_q      <= '0;
      chan_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (byte_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            chan_q  <= pop_data_i.chan;
            step_q  <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(STAMP_W - 1)) begin
            left_q  <= DIGIT_CNT_W'(NUM_DIGITS);
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_now) begin
            left_q <= left_q - 1'b1;
          end else begin
            state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            out_byte_q  <= ASCII_ZERO + 8'(top_digit);
            out_last_q  <= 1'b0;
            left_q      <= left_q - 1'b1;
            if (left_q == DIGIT_CNT_W'(1)) begin
              state_q <= ST_COMMA;
            end
          end
        end
        ST_COMMA: begin
          if (out_free) begin
            out_byte_q  <= ASCII_COMMA;
            out_last_q  <= 1'b0;
            state_q     <= ST_CHAN;
          end
        end
        ST_CHAN: begin
          if (out_free) begin
            out_byte_q  <= ASCII_ONE + 8'(chan_q);
            out_last_q  <= 1'b0;
            state_q     <= ST_CR;
          end
        end
        ST_CR: begin
          if (out_free) begin
            out_byte_q  <= ASCII_CR;
            out_last_q  <= 1'b0;
            state_q     <= ST_LF;
          end
        end
        ST_LF: begin
          if (out_free) begin
            out_byte_q  <= ASCII_LF;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // conversion datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bin_q <= pop_data_i.stamp;
      bcd_q <= '0;
    end else if (state_q == ST_CONV) begin
      bin_q <= {bin_q[STAMP_W-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[STAMP_W-1]};
    end else if (((state_q == ST_SKIP) && skip_now) ||
                 ((state_q == ST_DIGIT) && out_free)) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/event_timestamp_ascii_emitter.sv
// ----------------------------------------------------------------------------
// event_timestamp_ascii_emitter
// Timing events in, one ASCII timestamp record per accepted event with a valid base out.
// ----------------------------------------------------------------------------
// Input stream: one event per transfer. tdata carries now_ms, the 10 us tick
// count and base_time; tuser carries the channel and the base valid flag.
// Events inside the per-channel lockout window are swallowed; accepted
// events with a valid base give a record "<decimal>,<1|2>\r\n", one byte per
// output transfer, tlast on the line feed. Dropped events give nothing.
// Two front stages (filter, then ticks / 10) are registered before the
// queue write. The back end then pops the entry, runs the shift-add-3
// conversion over every stamp bit, skips leading zeros, outputs the
// digits, then comma, channel, CR and LF. It pops the next queued event
// only after the LF of the current record is loaded. The front keeps
// taking events while the back end works, until its two-entry queue
// and two stages are full. A sink stall holds the output register and
// the back end waits; nothing is lost. Reset clears the last event
// times to 0 and lockout to 50 ms.
// The lockout register sits at APB byte address 0; write it only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module event_timestamp_ascii_emitter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input events
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [31:0] now_ms, [63:32] sub_ticks, [127:64] base_time
  input  wire logic [127:0]                       s_axis_tdata,
  // [0] channel, [1] base_valid
  input  wire logic [1:0]                         s_axis_tuser,
  // record bytes
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]                              m_axis_tdata,
  output logic                                    m_axis_tlast,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [etae_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [etae_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [etae_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);
  import etae_pkg::*;

  logic [LOCKOUT_W-1:0] lockout_q;
  logic                 cfg_wr;

  logic                 push;
  stamp_entry_t         push_data;
  logic                 pop;
  stamp_entry_t         pop_data;
  fifo_status_t         fifo_status;

  // Register file: single lockout register, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LOCKOUT);
  assign prdata = (paddr == ADDR_LOCKOUT) ? APB_DATA_W'(lockout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RESET;
    end else if (cfg_wr) begin
      lockout_q <= pwdata[LOCKOUT_W-1:0];
    end
  end

  // Front: lockout filter and timestamp sum
  etae_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lockout_i     (lockout_q),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .channel_i     (s_axis_tuser[0]),
    .now_ms_i      (s_axis_tdata[31:0]),
    .sub_ticks_i   (s_axis_tdata[63:32]),
    .base_time_i   (s_axis_tdata[127:64]),
    .base_valid_i  (s_axis_tuser[1]),
    .push_o        (push),
    .push_data_o   (push_data),
    .fifo_status_i (fifo_status)
  );

  // Queue decouples the filter from the slow conversion
  etae_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  // Back: decimal conversion and byte output register
  etae_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_byte_o      (m_axis_tdata),
    .m_last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/etae_checker.sv
// ----------------------------------------------------------------------------
// etae_checker
// Port-level checks of the record output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_timestamp_ascii_emitter_assert.svh"

module etae_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);
  import etae_pkg::*;

  // stalled byte holds
  `ETAE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

  // record ends on a line feed
  `ETAE_ASSERT_NOW(a_last_is_lf, m_axis_tvalid && m_axis_tlast, m_axis_tdata == ASCII_LF, "tlast on a byte other than LF")

  // a line feed always closes the record
  `ETAE_ASSERT_NOW(a_lf_is_last, m_axis_tvalid && (m_axis_tdata == ASCII_LF), m_axis_tlast, "LF without tlast")

  // body bytes are digits, comma, channel char or CR
  `ETAE_ASSERT_NOW(a_body_chars, m_axis_tvalid && !m_axis_tlast, ((m_axis_tdata >= ASCII_ZERO) && (m_axis_tdata <= ASCII_NINE)) || (m_axis_tdata == ASCII_COMMA) || (m_axis_tdata == ASCII_CR), "unexpected character in record")

endmodule

bind event_timestamp_ascii_emitter etae_checker u_checker (.*);

`default_nettype wire
